// ===== rtl/fdvs_pkg.sv =====
// ----------------------------------------------------------------------------
// fdvs_pkg
// Shared widths, register codes, command types and helpers of the
// filtered decay voice shaper.
// ----------------------------------------------------------------------------
package fdvs_pkg;

    // Sample format and envelope precision.
    localparam int SAMPLE_BITS   = 16;
    localparam int ENV_FRAC_BITS = 24;

    // Port widths that the interface fixes.
    localparam int IN_W   = 16;
    localparam int PCM_W  = 16;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 25;

    // Filter format Q1.FILT_FRAC.
    localparam int FILT_FRAC = SAMPLE_BITS + 7;
    localparam int FILT_W    = FILT_FRAC + 1;
    localparam int DIFF_W    = FILT_W + 1;
    localparam int IN_SHIFT  = FILT_FRAC - (SAMPLE_BITS - 1);

    // Coefficient formats.
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam int RATIO_W    = 25;
    localparam int RATIO_FRAC = 24;
    localparam int VOL_W      = 16;
    localparam int VOL_FRAC   = 15;
    localparam int ENV_W      = ENV_FRAC_BITS + 1;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC;
    localparam logic [ENV_W-1:0]   ENV_ONE   = ENV_W'(1) << ENV_FRAC_BITS;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(32768);
    localparam logic [VOL_W-1:0]   VOL_RST   = VOL_W'(22938);

    // Shared signed multiplier; every operand fits with a sign bit.
    localparam int MW_0  = (DIFF_W > FILT_W) ? DIFF_W : FILT_W;
    localparam int MW_1  = (MW_0 > ENV_W + 1) ? MW_0 : ENV_W + 1;
    localparam int MW_2  = (MW_1 > RATIO_W + 1) ? MW_1 : RATIO_W + 1;
    localparam int MUL_W = (MW_2 > ALPHA_W + 1) ? MW_2 : ALPHA_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Output scaling: clamp limit 2^LIM_SHIFT, full scale 2^PCM_SHIFT - 1.
    localparam int LIM_SHIFT = FILT_FRAC + VOL_FRAC;
    localparam int MAG_W     = LIM_SHIFT + 1;
    localparam int PCM_SHIFT = 15;
    localparam int SCL_W     = MAG_W + PCM_SHIFT;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_ALPHA  = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_RATIO  = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] CFG_VOLUME = CFG_IW'(2);

    // Operand pairs of the shared multiplier.
    typedef enum logic [1:0] {
        MS_ALPHA_DIFF  = 2'd0,
        MS_FILT_ENV    = 2'd1,
        MS_ENV_RATIO   = 2'd2,
        MS_SCALED_VOL  = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     upd_filter;
        logic     upd_scaled;
        logic     upd_env;
        logic     clamp_en;
        logic     pcm_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    // Arithmetic right shift that rounds toward zero.
    function automatic logic signed [PROD_W-1:0] shr0(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              sh
    );
        logic [PROD_W-1:0] m;
        m = v[PROD_W-1] ? (~v + PROD_W'(1)) : v;
        m = m >> sh;
        return v[PROD_W-1] ? $signed(~m + PROD_W'(1)) : $signed(m);
    endfunction

endpackage

// ===== rtl/fdvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdvs_ctrl
// Sequencer that steps one sample through the shared multiplier datapath.
// ----------------------------------------------------------------------------
module fdvs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fdvs_pkg::t_dp_stat i_stat,
    output fdvs_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL_D  = 8'b0000_0010,
        ST_UPD_F  = 8'b0000_0100,
        ST_MUL_S  = 8'b0000_1000,
        ST_UPD_S  = 8'b0001_0000,
        ST_UPD_E  = 8'b0010_0000,
        ST_CLAMP  = 8'b0100_0000,
        ST_PCM    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_sel  = fdvs_pkg::MS_ALPHA_DIFF;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fdvs_pkg::MS_ALPHA_DIFF;
                n_state       = ST_UPD_F;
            end
            ST_UPD_F: begin
                o_cmd.upd_filter = 1'b1;
                n_state          = ST_MUL_S;
            end
            ST_MUL_S: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fdvs_pkg::MS_FILT_ENV;
                n_state       = ST_UPD_S;
            end
            ST_UPD_S: begin
                // The envelope product does not depend on the scaled sample.
                o_cmd.upd_scaled = 1'b1;
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_sel    = fdvs_pkg::MS_ENV_RATIO;
                n_state          = ST_UPD_E;
            end
            ST_UPD_E: begin
                o_cmd.upd_env = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fdvs_pkg::MS_SCALED_VOL;
                n_state       = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.clamp_en = 1'b1;
                n_state        = ST_PCM;
            end
            ST_PCM: begin
                if (i_stat.out_free) begin
                    o_cmd.pcm_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule

// ===== rtl/fdvs_datapath.sv =====
// ----------------------------------------------------------------------------
// fdvs_datapath
// Configuration registers, filter and envelope state, shared multiplier,
// clamp and PCM scaling, and the output register.
// ----------------------------------------------------------------------------
module fdvs_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fdvs_pkg::t_dp_cmd                   i_cmd,
    output fdvs_pkg::t_dp_stat                  o_stat,
    input  logic                                i_clip_start,
    input  logic signed [fdvs_pkg::IN_W-1:0]    i_sample_in,
    input  logic                                i_cfg_valid,
    input  logic [fdvs_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [fdvs_pkg::CFG_DW-1:0]         i_cfg_data,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic signed [fdvs_pkg::PCM_W-1:0]   o_pcm_out,
    output logic                                o_clipped
);

    localparam logic signed [fdvs_pkg::PROD_W-1:0] LIM =
        fdvs_pkg::PROD_W'(1) << fdvs_pkg::LIM_SHIFT;
    localparam logic signed [fdvs_pkg::PROD_W-1:0] NEG_LIM = -LIM;

    logic [fdvs_pkg::ALPHA_W-1:0]          r_alpha;
    logic [fdvs_pkg::RATIO_W-1:0]          r_ratio;
    logic [fdvs_pkg::VOL_W-1:0]            r_volume;

    logic signed [fdvs_pkg::FILT_W-1:0]    r_x;
    logic signed [fdvs_pkg::FILT_W-1:0]    r_filter;
    logic [fdvs_pkg::ENV_W-1:0]            r_env;
    logic signed [fdvs_pkg::FILT_W-1:0]    r_scaled;
    logic signed [fdvs_pkg::PROD_W-1:0]    r_prod;
    logic [fdvs_pkg::MAG_W-1:0]            r_mag;
    logic                                  r_neg;
    logic                                  r_clip;

    logic                                  r_out_valid;
    logic signed [fdvs_pkg::PCM_W-1:0]     r_pcm;
    logic                                  r_out_clip;

    logic [fdvs_pkg::SAMPLE_BITS-1:0]      raw;
    logic signed [fdvs_pkg::FILT_W-1:0]    x_ext;
    logic signed [fdvs_pkg::DIFF_W-1:0]    diff;
    logic signed [fdvs_pkg::MUL_W-1:0]     op_a;
    logic signed [fdvs_pkg::MUL_W-1:0]     op_b;
    logic [fdvs_pkg::PROD_W-1:0]           prod_abs;
    logic [fdvs_pkg::SCL_W-1:0]            scaled_mag;
    logic [fdvs_pkg::PCM_W-1:0]            pcm_mag;

    // Configuration; alpha and ratio saturate at one when written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= fdvs_pkg::ALPHA_RST;
            r_ratio  <= fdvs_pkg::RATIO_ONE;
            r_volume <= fdvs_pkg::VOL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fdvs_pkg::CFG_ALPHA: begin
                    r_alpha <= (i_cfg_data[fdvs_pkg::ALPHA_W-1:0] > fdvs_pkg::ALPHA_ONE)
                               ? fdvs_pkg::ALPHA_ONE : i_cfg_data[fdvs_pkg::ALPHA_W-1:0];
                end
                fdvs_pkg::CFG_RATIO: begin
                    r_ratio <= (i_cfg_data[fdvs_pkg::RATIO_W-1:0] > fdvs_pkg::RATIO_ONE)
                               ? fdvs_pkg::RATIO_ONE : i_cfg_data[fdvs_pkg::RATIO_W-1:0];
                end
                fdvs_pkg::CFG_VOLUME: begin
                    r_volume <= i_cfg_data[fdvs_pkg::VOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input sample moved to the filter format.
    assign raw   = fdvs_pkg::SAMPLE_BITS'($unsigned(i_sample_in));
    assign x_ext = fdvs_pkg::FILT_W'($signed(raw)) <<< fdvs_pkg::IN_SHIFT;
    assign diff  = fdvs_pkg::DIFF_W'(r_x) - fdvs_pkg::DIFF_W'(r_filter);

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.mul_sel)
            fdvs_pkg::MS_ALPHA_DIFF: begin
                op_a = fdvs_pkg::MUL_W'($signed({1'b0, r_alpha}));
                op_b = fdvs_pkg::MUL_W'(diff);
            end
            fdvs_pkg::MS_FILT_ENV: begin
                op_a = fdvs_pkg::MUL_W'(r_filter);
                op_b = fdvs_pkg::MUL_W'($signed({1'b0, r_env}));
            end
            fdvs_pkg::MS_ENV_RATIO: begin
                op_a = fdvs_pkg::MUL_W'($signed({1'b0, r_env}));
                op_b = fdvs_pkg::MUL_W'($signed({1'b0, r_ratio}));
            end
            fdvs_pkg::MS_SCALED_VOL: begin
                op_a = fdvs_pkg::MUL_W'(r_scaled);
                op_b = fdvs_pkg::MUL_W'($signed({1'b0, r_volume}));
            end
            default: begin
            end
        endcase
    end

    assign prod_abs = r_prod[fdvs_pkg::PROD_W-1] ? (~r_prod + fdvs_pkg::PROD_W'(1)) : r_prod;

    // Clip state and the envelope live across items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= '0;
            r_env    <= fdvs_pkg::ENV_ONE;
        end else begin
            if (i_cmd.load && i_clip_start) begin
                r_filter <= '0;
                r_env    <= fdvs_pkg::ENV_ONE;
            end
            if (i_cmd.upd_filter) begin
                r_filter <= r_filter + fdvs_pkg::FILT_W'(
                    fdvs_pkg::shr0(r_prod, fdvs_pkg::ALPHA_FRAC));
            end
            if (i_cmd.upd_env) begin
                r_env <= fdvs_pkg::ENV_W'($unsigned(r_prod) >> fdvs_pkg::RATIO_FRAC);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= x_ext;
        end
        if (i_cmd.mul_en) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.upd_scaled) begin
            r_scaled <= fdvs_pkg::FILT_W'(fdvs_pkg::shr0(r_prod, fdvs_pkg::ENV_FRAC_BITS));
        end
        if (i_cmd.clamp_en) begin
            r_neg <= r_prod[fdvs_pkg::PROD_W-1];
            if (r_prod > LIM || r_prod < NEG_LIM) begin
                r_mag  <= fdvs_pkg::MAG_W'(LIM);
                r_clip <= 1'b1;
            end else begin
                r_mag  <= fdvs_pkg::MAG_W'(prod_abs);
                r_clip <= 1'b0;
            end
        end
    end

    // Multiply by 2^15 - 1 as a shift and a subtract.
    assign scaled_mag = {r_mag, fdvs_pkg::PCM_SHIFT'(0)} - fdvs_pkg::SCL_W'(r_mag);
    assign pcm_mag    = fdvs_pkg::PCM_W'(scaled_mag >> fdvs_pkg::LIM_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pcm_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pcm_load) begin
            r_pcm      <= r_neg ? $signed(~pcm_mag + fdvs_pkg::PCM_W'(1)) : $signed(pcm_mag);
            r_out_clip <= r_clip;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_pcm_out       = r_pcm;
    assign o_clipped       = r_out_clip;

endmodule

// ===== rtl/filtered_decay_voice_shaper_core.sv =====
// ----------------------------------------------------------------------------
// filtered_decay_voice_shaper_core
// One-pole low-pass filter followed by an exponential decay envelope,
// master volume, clamp and truncation to 16-bit PCM.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid / o_ready) carries one signed sample and a
// clip_start flag per transaction. The output channel (o_valid / i_ready)
// returns one PCM sample and a clipped flag for every input transaction,
// in order. The configuration channel (i_cfg_valid / o_cfg_ready) writes
// filter_alpha (index 0), decay_ratio (index 1) and master_volume (index 2);
// other indexes are ignored. It is always ready and must only be used while
// the block is idle.
// Timing: an accepted sample steps through MUL_D, UPD_F, MUL_S, UPD_S,
// UPD_E, CLAMP and PCM, where its result goes into the output register;
// a new sample is only taken back in the idle step. The steps are set by
// the single shared multiplier, which is used four times per sample, plus
// a filter update, a clamp and a scaling step.
// Reset (synchronous, active low) restores the register defaults, clears the
// filter, sets the envelope to 1.0 and empties the output register.
// When the receiver stalls, the finished result holds in the output
// register and the next sample is still accepted and processed; the
// sequencer waits in its last step only if the previous result is still
// waiting to be taken.
// ----------------------------------------------------------------------------
module filtered_decay_voice_shaper_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_clip_start,
    input  logic signed [fdvs_pkg::IN_W-1:0]    i_sample_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [fdvs_pkg::PCM_W-1:0]   o_pcm_out,
    output logic                                o_clipped,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fdvs_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [fdvs_pkg::CFG_DW-1:0]         i_cfg_data
);

    // Commands flow from the sequencer to the datapath; status flows back.
    fdvs_pkg::t_dp_cmd  cmd;
    fdvs_pkg::t_dp_stat stat;

    // Configuration writes complete in the cycle they are presented.
    assign o_cfg_ready = 1'b1;

    fdvs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fdvs_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_clip_start (i_clip_start),
        .i_sample_in  (i_sample_in),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_pcm_out    (o_pcm_out),
        .o_clipped    (o_clipped)
    );

    // The sequencer is busy in the cycle after it accepts a sample.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready
    ) else $error("input accepted while a sample is still in flight");

    // A new result is never written over one that is still waiting.
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.pcm_load |-> stat.out_free
    ) else $error("pending result overwritten");

    // A clamped result is full scale.
    a_clip_full_scale: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            (o_pcm_out == 16'sd32767 || o_pcm_out == -16'sd32767)
    ) else $error("clipped result is not full scale");

    // The PCM range is symmetric.
    a_no_most_negative: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pcm_out != 16'sh8000)
    ) else $error("PCM result out of range");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voice shaper core testbench
// Drives signed samples with clip markers through the low-pass, decay
// envelope, volume and clamp path of filtered_decay_voice_shaper_core, and
// checks every PCM result against a bit-exact fixed-point predictor kept in
// step with the register writes. A short table of directed rows comes first.
// Random clips follow under a series of register settings, with bursty input
// traffic, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    // Timing of the run. The watchdog limit covers the long hold-off, the
    // largest sender gap and the processing time of a sample, with a wide
    // margin on top.
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 24;
    localparam int WATCHDOG_LIMIT  = 5000;

    // Shape of the stimulus.
    localparam int DIR_ROWS        = 33;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 108;
    localparam int HOLD_PHASE      = 4;

    // The index port has one code above the last register; writes to it
    // must leave every register alone.
    localparam logic [fdvs_pkg::CFG_IW-1:0] CFG_UNUSED = fdvs_pkg::CFG_IW'(3);

    // Full-scale PCM magnitude used by the final scaling step.
    localparam longint PCM_FULL_SCALE = 32767;

    // Kinds of rows in the directed table. Known rows carry the expected
    // result typed in; sample rows are checked against the predictor.
    typedef enum logic [1:0] {
        ROW_WRITE  = 2'd0,
        ROW_SAMPLE = 2'd1,
        ROW_KNOWN  = 2'd2
    } t_row_kind;

    typedef struct packed {
        t_row_kind                         kind;
        logic [fdvs_pkg::CFG_IW-1:0]       index;
        logic signed [31:0]                value;
        logic                              clip;
        logic signed [fdvs_pkg::PCM_W-1:0] pcm;
        logic                              clipped;
    } t_plan_row;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        SINK_OPEN     = 2'd0,
        SINK_COIN     = 2'd1,
        SINK_MOSTLY   = 2'd2,
        SINK_PERIODIC = 2'd3
    } t_sink_mode;

    typedef struct packed {
        logic signed [fdvs_pkg::PCM_W-1:0] pcm;
        logic                              clipped;
    } t_shaped;

    // Ports of the block.
    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_ready;
    logic                               i_clip_start;
    logic signed [fdvs_pkg::IN_W-1:0]   i_sample_in;
    logic                               o_valid;
    logic                               i_ready;
    logic signed [fdvs_pkg::PCM_W-1:0]  o_pcm_out;
    logic                               o_clipped;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [fdvs_pkg::CFG_IW-1:0]        i_cfg_index;
    logic [fdvs_pkg::CFG_DW-1:0]        i_cfg_data;

    // Shadow copies of the registers and of the filter and envelope.
    logic [fdvs_pkg::ALPHA_W-1:0] alpha_mirror;
    logic [fdvs_pkg::RATIO_W-1:0] ratio_mirror;
    logic [fdvs_pkg::VOL_W-1:0]   volume_mirror;
    longint                       filter_state;
    longint                       envelope_state;

    // Results still owed by the block, oldest first.
    t_shaped shaped_expect[$];

    t_plan_row dir_plan [DIR_ROWS];

    int  errors;
    int  results_seen;
    int  items_sent;
    int  clips_started;
    int  clamps_expected;
    int  writes_done;
    int  hold_asks;
    int  holds_done;
    int  quiet_cycles;

    filtered_decay_voice_shaper_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_clip_start (i_clip_start),
        .i_sample_in  (i_sample_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pcm_out    (o_pcm_out),
        .o_clipped    (o_clipped),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Arithmetic right shift whose result is rounded toward zero.
    function automatic longint trunc_shift(input longint v, input int sh);
        if (v < 0) return -((-v) >>> sh);
        return v >>> sh;
    endfunction

    // Advances the shadow filter and envelope by one sample and returns the
    // PCM value and clamp flag that the block should produce for it.
    function automatic t_shaped shape_sample(
        input bit clip,
        input logic signed [fdvs_pkg::IN_W-1:0] smp
    );
        longint  x, gain, ratio, scaled, v, lim, p;
        t_shaped res;
        // The sample is aligned to the filter's fraction before anything else.
        x = longint'(smp) * (longint'(1) <<< fdvs_pkg::IN_SHIFT);
        if (clip) begin
            filter_state   = 0;
            envelope_state = longint'(fdvs_pkg::ENV_ONE);
        end
        gain = (alpha_mirror > fdvs_pkg::ALPHA_ONE) ? longint'(fdvs_pkg::ALPHA_ONE)
                                                    : longint'(alpha_mirror);
        filter_state = filter_state
                     + trunc_shift(gain * (x - filter_state), fdvs_pkg::ALPHA_FRAC);
        // The envelope scales this sample before it decays for the next one.
        scaled = trunc_shift(filter_state * envelope_state, fdvs_pkg::ENV_FRAC_BITS);
        ratio  = (ratio_mirror > fdvs_pkg::RATIO_ONE) ? longint'(fdvs_pkg::RATIO_ONE)
                                                      : longint'(ratio_mirror);
        envelope_state = (envelope_state * ratio) >>> fdvs_pkg::RATIO_FRAC;
        v   = scaled * longint'(volume_mirror);
        lim = longint'(1) <<< fdvs_pkg::LIM_SHIFT;
        res.clipped = 1'b0;
        if (v > lim) begin
            v = lim;
            res.clipped = 1'b1;
        end else if (v < -lim) begin
            v = -lim;
            res.clipped = 1'b1;
        end
        p = trunc_shift(v * PCM_FULL_SCALE, fdvs_pkg::LIM_SHIFT);
        res.pcm = p[fdvs_pkg::PCM_W-1:0];
        return res;
    endfunction

    // Mirrors one register write; bits above a register's width are dropped
    // and the spare index does nothing.
    function automatic void mirror_write(input logic [fdvs_pkg::CFG_IW-1:0] idx,
                                         input logic [fdvs_pkg::CFG_DW-1:0] data);
        case (idx)
            fdvs_pkg::CFG_ALPHA:  alpha_mirror  = data[fdvs_pkg::ALPHA_W-1:0];
            fdvs_pkg::CFG_RATIO:  ratio_mirror  = data[fdvs_pkg::RATIO_W-1:0];
            fdvs_pkg::CFG_VOLUME: volume_mirror = data[fdvs_pkg::VOL_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        errors++;
        $display("[%0t] result %0d: %0s is %0d, expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    // Output transactions are sampled at the rising edge, where the values
    // seen are the ones that the edge accepts.
    always @(posedge i_clk) begin : result_check
        t_shaped want;
        if (i_rst_n && o_valid && i_ready) begin
            if (shaped_expect.size() == 0) begin
                report_mismatch("pcm_out with no sample pending", o_pcm_out, 0);
            end else begin
                want = shaped_expect.pop_front();
                if (o_pcm_out !== want.pcm)
                    report_mismatch("pcm_out", o_pcm_out, want.pcm);
                if (o_clipped !== want.clipped)
                    report_mismatch("clipped", o_clipped, want.clipped);
            end
            results_seen++;
        end
    end

    // The watchdog ends the run when no channel has moved a transaction for
    // far longer than any correct run can stay quiet.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------

    // The receiver switches between randomly chosen stall patterns.
    // When the stimulus asks for a hold-off it keeps ready low for a long
    // stretch, counted here, so that the block fills up and stalls its input.
    initial begin : result_sink
        t_sink_mode mode;
        int         mode_left;
        int         tick;
        mode      = SINK_OPEN;
        mode_left = 0;
        tick      = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (holds_done < hold_asks) begin
                holds_done++;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(64, 256);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   i_ready <= 1'b1;
                    SINK_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    SINK_MOSTLY: i_ready <= ($urandom_range(0, 7) != 0);
                    default:     i_ready <= ((tick % 5) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and register writes
    // ------------------------------------------------------------------

    // Offers one sample transaction, starting at a falling edge, and returns
    // at the falling edge after it was accepted. Valid is left high so that
    // the caller either offers the next sample or lowers it.
    task automatic offer_sample(input bit clip,
                                input logic signed [fdvs_pkg::IN_W-1:0] smp,
                                input bit use_table, input t_shaped table_res);
        t_shaped predicted;
        i_valid      <= 1'b1;
        i_clip_start <= clip;
        i_sample_in  <= smp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = shape_sample(clip, smp);
        shaped_expect.push_back(use_table ? table_res : predicted);
        items_sent++;
        if (clip) clips_started++;
        if (predicted.clipped) clamps_expected++;
        @(negedge i_clk);
    endtask

    // Writes one register. Valid is lowered again before the task returns.
    task automatic write_reg(input logic [fdvs_pkg::CFG_IW-1:0] idx,
                             input logic [fdvs_pkg::CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mirror_write(idx, data);
        writes_done++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Every sample yields exactly one result, so an empty queue means the
    // block has nothing left in flight and registers may be written.
    task automatic wait_drained();
        while (shaped_expect.size() != 0) @(negedge i_clk);
    endtask

    // Picks and writes the settings of one random phase. The first phases
    // pin the extremes; upper data bits beyond a register are random.
    task automatic program_phase(input int ph);
        logic [fdvs_pkg::ALPHA_W-1:0] a;
        logic [fdvs_pkg::RATIO_W-1:0] r;
        logic [fdvs_pkg::VOL_W-1:0]   v;
        logic [fdvs_pkg::CFG_DW-1:0]  pad;
        wait_drained();
        if (ph == 0) begin
            a = '1;
            r = '1;
            v = '1;
        end else if (ph == 1) begin
            a = fdvs_pkg::ALPHA_W'(1);
            r = '0;
            v = fdvs_pkg::VOL_W'(32768);
        end else if (ph == 2) begin
            a = '0;
            r = fdvs_pkg::RATIO_ONE;
            v = '1;
        end else begin
            case ($urandom_range(0, 5))
                0:       a = '0;
                1:       a = fdvs_pkg::ALPHA_ONE;
                2:       a = fdvs_pkg::ALPHA_W'($urandom_range(65537, 131071));
                3:       a = fdvs_pkg::ALPHA_W'($urandom_range(1, 4000));
                default: a = fdvs_pkg::ALPHA_W'($urandom_range(0, 65536));
            endcase
            case ($urandom_range(0, 6))
                0:       r = '0;
                1:       r = fdvs_pkg::RATIO_ONE;
                2:       r = fdvs_pkg::RATIO_W'($urandom_range(32'h100_0001, 32'h1FF_FFFF));
                3, 4:    r = fdvs_pkg::RATIO_W'(32'h100_0000 - $urandom_range(1, 300000));
                default: r = fdvs_pkg::RATIO_W'($urandom_range(0, 32'h100_0000));
            endcase
            case ($urandom_range(0, 5))
                0:       v = '0;
                1:       v = '1;
                2:       v = fdvs_pkg::VOL_W'(32768);
                default: v = fdvs_pkg::VOL_W'($urandom);
            endcase
        end
        pad = fdvs_pkg::CFG_DW'($urandom);
        write_reg(fdvs_pkg::CFG_ALPHA, {pad[fdvs_pkg::CFG_DW-1:fdvs_pkg::ALPHA_W], a});
        write_reg(fdvs_pkg::CFG_RATIO, r);
        write_reg(fdvs_pkg::CFG_VOLUME, {pad[fdvs_pkg::CFG_DW-1:fdvs_pkg::VOL_W], v});
        if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, fdvs_pkg::CFG_DW'($urandom));
    endtask

    // Samples lean on full scale and near-silence as well as plain noise.
    function automatic logic signed [fdvs_pkg::IN_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return fdvs_pkg::IN_W'(int'($urandom_range(0, 511)) - 256);
            default: return fdvs_pkg::IN_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        t_plan_row row;
        t_shaped   known;
        bit        clip;
        int        clip_left;
        int        burst_left;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_clip_start = 1'b0;
        i_sample_in  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = fdvs_pkg::CFG_ALPHA;
        i_cfg_data   = '0;
        hold_asks    = 0;
        clip_left    = 0;

        // Register defaults and a clear filter with the envelope at one.
        alpha_mirror   = fdvs_pkg::ALPHA_RST;
        ratio_mirror   = fdvs_pkg::RATIO_ONE;
        volume_mirror  = fdvs_pkg::VOL_RST;
        filter_state   = 0;
        envelope_state = longint'(fdvs_pkg::ENV_ONE);

        // Directed rows: kind, index, value (data or sample), clip flag,
        // and for known rows the expected pcm and clamp flag. With the
        // filter gain and the decay ratio both at one, the filter tracks the
        // input and full volume (0x8000) maps a sample x to x*32767/32768.
        // The index field of a sample row is not used.
        dir_plan = '{
            // Defaults after reset; a silent first sample gives silence.
            '{ROW_KNOWN,  CFG_UNUSED,           0,           1'b1, 16'sd0,      1'b0},
            '{ROW_SAMPLE, CFG_UNUSED,           32767,       1'b0, 16'sd0,      1'b0},
            '{ROW_SAMPLE, CFG_UNUSED,           -32768,      1'b0, 16'sd0,      1'b0},
            // Gain and ratio above one saturate; the volume keeps its low
            // 16 bits (0x8000); the spare index is ignored.
            '{ROW_WRITE,  fdvs_pkg::CFG_ALPHA,  'h1FF_FFFF,  1'b0, 16'sd0,      1'b0},
            '{ROW_WRITE,  fdvs_pkg::CFG_RATIO,  'h1FF_FFFF,  1'b0, 16'sd0,      1'b0},
            '{ROW_WRITE,  fdvs_pkg::CFG_VOLUME, 'h1FF_8000,  1'b0, 16'sd0,      1'b0},
            '{ROW_WRITE,  CFG_UNUSED,           'h155_5555,  1'b0, 16'sd0,      1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           32767,       1'b1, 16'sd32766,  1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           -32768,      1'b1, -16'sd32767, 1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           1,           1'b0, 16'sd0,      1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           -1,          1'b0, 16'sd0,      1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           16384,       1'b0, 16'sd16383,  1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           -16384,      1'b0, -16'sd16383, 1'b0},
            // Top volume drives full-scale input into the clamp.
            '{ROW_WRITE,  fdvs_pkg::CFG_VOLUME, 65535,       1'b0, 16'sd0,      1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           32767,       1'b1, 16'sd32767,  1'b1},
            '{ROW_KNOWN,  CFG_UNUSED,           -32768,      1'b0, -16'sd32767, 1'b1},
            '{ROW_KNOWN,  CFG_UNUSED,           0,           1'b0, 16'sd0,      1'b0},
            // A zero gain holds the cleared filter at zero.
            '{ROW_WRITE,  fdvs_pkg::CFG_ALPHA,  0,           1'b0, 16'sd0,      1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           32767,       1'b1, 16'sd0,      1'b0},
            // A zero ratio lets the first sample through, then the envelope
            // has underflowed and stays at zero.
            '{ROW_WRITE,  fdvs_pkg::CFG_ALPHA,  65536,       1'b0, 16'sd0,      1'b0},
            '{ROW_WRITE,  fdvs_pkg::CFG_RATIO,  0,           1'b0, 16'sd0,      1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           32767,       1'b1, 16'sd32767,  1'b1},
            '{ROW_KNOWN,  CFG_UNUSED,           32767,       1'b0, 16'sd0,      1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           -32768,      1'b0, 16'sd0,      1'b0},
            // A slow filter with a real decay, checked by the predictor.
            '{ROW_WRITE,  fdvs_pkg::CFG_ALPHA,  1000,        1'b0, 16'sd0,      1'b0},
            '{ROW_WRITE,  fdvs_pkg::CFG_RATIO,  16000000,    1'b0, 16'sd0,      1'b0},
            '{ROW_WRITE,  fdvs_pkg::CFG_VOLUME, 22938,       1'b0, 16'sd0,      1'b0},
            '{ROW_SAMPLE, CFG_UNUSED,           -32768,      1'b1, 16'sd0,      1'b0},
            '{ROW_SAMPLE, CFG_UNUSED,           12345,       1'b0, 16'sd0,      1'b0},
            '{ROW_SAMPLE, CFG_UNUSED,           32767,       1'b0, 16'sd0,      1'b0},
            '{ROW_SAMPLE, CFG_UNUSED,           -32768,      1'b0, 16'sd0,      1'b0},
            // Zero volume silences everything.
            '{ROW_WRITE,  fdvs_pkg::CFG_VOLUME, 0,           1'b0, 16'sd0,      1'b0},
            '{ROW_KNOWN,  CFG_UNUSED,           32767,       1'b0, 16'sd0,      1'b0}
        };

        // Synchronous reset, applied once at the start of the run.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Samples are offered back to back; before a
        // register write the sender goes quiet and waits for the block to
        // drain.
        for (int k = 0; k < DIR_ROWS; k++) begin
            row = dir_plan[k];
            case (row.kind)
                ROW_WRITE: begin
                    i_valid <= 1'b0;
                    wait_drained();
                    write_reg(row.index, fdvs_pkg::CFG_DW'(row.value));
                end
                ROW_SAMPLE: begin
                    offer_sample(row.clip, fdvs_pkg::IN_W'(row.value), 1'b0, '0);
                end
                default: begin
                    known.pcm     = row.pcm;
                    known.clipped = row.clipped;
                    offer_sample(row.clip, fdvs_pkg::IN_W'(row.value), 1'b1, known);
                end
            endcase
        end
        i_valid <= 1'b0;

        // Random part. Each phase drains the block, writes new settings and
        // then sends clips: a clip start followed by a run of samples, with
        // the odd stray clip start mixed in. Traffic comes in bursts with
        // random gaps, and now and then a long burst with no gap at all.
        // In the hold-off phase the sender never pauses, so the block backs
        // up while the receiver holds ready low.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            program_phase(ph);
            burst_left = 0;
            if (ph == HOLD_PHASE) hold_asks++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph != HOLD_PHASE && burst_left <= 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge i_clk);
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 24);
                end
                if (clip_left == 0) begin
                    clip      = 1'b1;
                    clip_left = $urandom_range(3, 80);
                end else begin
                    clip = ($urandom_range(0, 31) == 0);
                    clip_left--;
                end
                offer_sample(clip, draw_sample(), 1'b0, '0);
                burst_left--;
            end
            i_valid <= 1'b0;
        end

        // Let every owed result arrive, then watch a little longer for any
        // result that should not be there.
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d samples over %0d clip starts and %0d register writes.",
                 items_sent, clips_started, writes_done);
        $display("Checked %0d results (%0d clamped), receiver held off %0d time(s).",
                 results_seen, clamps_expected, holds_done);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
